/* design/krr_pkg.sv */
// ----------------------------------------------------------------------------
// krr_pkg
// Shared constants for the key press / auto-repeat reporter: field widths,
// register map, reset values and event kinds.
// ----------------------------------------------------------------------------
package krr_pkg;

    localparam int KEY_ROWS_DEF = 2;
    localparam int KEY_COLS_DEF = 2;

    localparam int TIME_W     = 32;
    localparam int CODE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int HOLD_W     = 16;
    localparam int MAP_W      = 32;
    localparam int MAP_CODES  = MAP_W / CODE_W;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [1:0] REG_HOLD_OFF = 2'd0;
    localparam logic [1:0] REG_REPEAT   = 2'd1;
    localparam logic [1:0] REG_KEY_MAP  = 2'd2;

    localparam logic [HOLD_W-1:0] HOLD_OFF_RST = 16'd50;
    localparam logic [HOLD_W-1:0] REPEAT_RST   = 16'd500;
    localparam logic [MAP_W-1:0]  KEY_MAP_RST  = 32'h0706_0504;

    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

endpackage

/* design/key_press_repeat_reporter_core.sv */
// ----------------------------------------------------------------------------
// key_press_repeat_reporter_core
// An accepted input beat is held in the input register, and its result beat in the output register.
// Throughput: one input beat per cycle unless an output beat stalls on m_tready; one subtract-compare per key sample.
// A sample that yields no report is dropped without an output beat.
// Reset: synchronous, active low; clears held flags, report times to zero
// and loads default hold-off, repeat and keymap registers.
// ----------------------------------------------------------------------------
module key_press_repeat_reporter_core #(
    parameter int KEY_ROWS = krr_pkg::KEY_ROWS_DEF,
    parameter int KEY_COLS = krr_pkg::KEY_COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: key_row[0], key_col[1], pressed[2], now_ms[34:3], zero pad
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [krr_pkg::IN_TDATA_W-1:0]    s_tdata,
    // m_tdata: key_code[7:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [krr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // m_tuser: event_kind[1:0]
    output logic [krr_pkg::OUT_TUSER_W-1:0]   m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [krr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [krr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [krr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import krr_pkg::*;

    localparam int SLOTS  = KEY_ROWS * KEY_COLS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [HOLD_W-1:0] hold_off_reg;
    logic [HOLD_W-1:0] repeat_reg;
    logic [MAP_W-1:0]  key_map_reg;

    logic              held_reg [SLOTS];
    logic [TIME_W-1:0] time_reg [SLOTS];

    logic              in_vld_reg;
    logic              row_reg;
    logic              col_reg;
    logic              press_reg;
    logic [TIME_W-1:0] now_reg;

    logic              out_vld_reg;
    logic [CODE_W-1:0] code_reg;
    logic [KIND_W-1:0] kind_reg;

    logic              proc;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;
    logic              in_range;
    logic [2:0]        slot_full;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        map_idx;
    logic              held_cur;
    logic [TIME_W-1:0] elapsed;
    logic              hit;
    logic              res_vld;
    logic              set_held;
    logic              clr_held;
    logic              upd_time;
    logic [CODE_W-1:0] res_code;
    logic [KIND_W-1:0] res_kind;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_HOLD_OFF: prdata = {{(APB_DATA_W-HOLD_W){1'b0}}, hold_off_reg};
            REG_REPEAT:   prdata = {{(APB_DATA_W-HOLD_W){1'b0}}, repeat_reg};
            REG_KEY_MAP:  prdata = key_map_reg;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_off_reg <= HOLD_OFF_RST;
            repeat_reg   <= REPEAT_RST;
            key_map_reg  <= KEY_MAP_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HOLD_OFF: hold_off_reg <= pwdata[HOLD_W-1:0];
                REG_REPEAT:   repeat_reg   <= pwdata[HOLD_W-1:0];
                REG_KEY_MAP:  key_map_reg  <= pwdata[MAP_W-1:0];
                default:      ;
            endcase
        end
    end

    assign proc     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            row_reg   <= s_tdata[0];
            col_reg   <= s_tdata[1];
            press_reg <= s_tdata[2];
            now_reg   <= s_tdata[34:3];
        end
    end

    assign in_range  = ({31'd0, row_reg} < 32'(KEY_ROWS))
                    && ({31'd0, col_reg} < 32'(KEY_COLS));
    assign slot_full = 3'({2'd0, row_reg} * 3'(KEY_COLS)) + {2'd0, col_reg};
    assign slot      = slot_full[SLOT_W-1:0];
    assign map_idx   = slot_full[1:0];
    assign held_cur  = held_reg[slot];
    assign elapsed   = now_reg - time_reg[slot];

    always_comb begin
        hit      = proc && in_range && ({29'd0, slot_full} < 32'(SLOTS));
        res_vld  = 1'b0;
        set_held = 1'b0;
        clr_held = 1'b0;
        upd_time = 1'b0;
        res_code = key_map_reg[map_idx*CODE_W +: CODE_W];
        res_kind = KIND_PRESS;
        if (hit) begin
            if (press_reg) begin
                if (!held_cur) begin
                    if (elapsed > {{(TIME_W-HOLD_W){1'b0}}, hold_off_reg}) begin
                        res_vld  = 1'b1;
                        set_held = 1'b1;
                        upd_time = 1'b1;
                    end
                end else if (elapsed > {{(TIME_W-HOLD_W){1'b0}}, repeat_reg}) begin
                    res_vld  = 1'b1;
                    upd_time = 1'b1;
                    res_kind = KIND_REPEAT;
                end
            end else if (held_cur) begin
                res_vld  = 1'b1;
                clr_held = 1'b1;
                res_code = '0;
                res_kind = KIND_RELEASE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                held_reg[i] <= 1'b0;
                time_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot == SLOT_W'(i)) begin
                    if (set_held) begin
                        held_reg[i] <= 1'b1;
                    end else if (clr_held) begin
                        held_reg[i] <= 1'b0;
                    end
                    if (upd_time) begin
                        time_reg[i] <= now_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc) begin
            out_vld_reg <= res_vld;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && res_vld) begin
            code_reg <= res_code;
            kind_reg <= res_kind;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = code_reg;
    assign m_tuser  = kind_reg;

endmodule

/* verif/key_press_repeat_reporter_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_press_repeat_reporter_core_test
// Drives key samples into the reporter with bursty input traffic and random
// output backpressure. A scoreboard keeps its own per-key held flags and
// report times, predicts the press, repeat and release reports, and compares
// each output beat field by field. Registers are rewritten between phases,
// covering zero and full-scale hold-off, repeat and keymap values.
// ----------------------------------------------------------------------------
module key_press_repeat_reporter_core_test;
    import krr_pkg::*;

    localparam int SLOTS      = KEY_ROWS_DEF * KEY_COLS_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [KIND_W-1:0] kind;
    } key_report_t;

    class key_report_scoreboard;
        logic [HOLD_W-1:0] hold_off_ms;
        logic [HOLD_W-1:0] repeat_ms;
        logic [MAP_W-1:0]  key_map;
        bit                held [SLOTS];
        logic [TIME_W-1:0] last_report [SLOTS];
        key_report_t       due_q [$];
        int                mismatches;

        function new();
            hold_off_ms = HOLD_OFF_RST;
            repeat_ms   = REPEAT_RST;
            key_map     = KEY_MAP_RST;
            mismatches  = 0;
            foreach (held[i]) begin
                held[i]        = 1'b0;
                last_report[i] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_HOLD_OFF: hold_off_ms = value[HOLD_W-1:0];
                REG_REPEAT:   repeat_ms   = value[HOLD_W-1:0];
                REG_KEY_MAP:  key_map     = value[MAP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [APB_DATA_W-1:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_HOLD_OFF: return APB_DATA_W'(hold_off_ms);
                REG_REPEAT:   return APB_DATA_W'(repeat_ms);
                REG_KEY_MAP:  return APB_DATA_W'(key_map);
                default:      return '0;
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
        endfunction

        function void note_sample(bit row, bit col, bit pressed, logic [TIME_W-1:0] now);
            int                slot;
            logic [TIME_W-1:0] elapsed;
            key_report_t       rpt;
            slot    = row * KEY_COLS_DEF + col;
            elapsed = now - last_report[slot];
            if (pressed) begin
                if (!held[slot] && elapsed > TIME_W'(hold_off_ms)) begin
                    held[slot]        = 1'b1;
                    last_report[slot] = now;
                    rpt.code          = key_map[slot*CODE_W +: CODE_W];
                    rpt.kind          = KIND_PRESS;
                    due_q.push_back(rpt);
                end else if (held[slot] && elapsed > TIME_W'(repeat_ms)) begin
                    last_report[slot] = now;
                    rpt.code          = key_map[slot*CODE_W +: CODE_W];
                    rpt.kind          = KIND_REPEAT;
                    due_q.push_back(rpt);
                end
            end else if (held[slot]) begin
                held[slot] = 1'b0;
                rpt.code   = '0;
                rpt.kind   = KIND_RELEASE;
                due_q.push_back(rpt);
            end
        endfunction

        function void check_report(logic [CODE_W-1:0] code, logic [KIND_W-1:0] kind);
            key_report_t want;
            if (due_q.size() == 0) begin
                flag($sformatf("unexpected report: code %02h kind %0d", code, kind));
                return;
            end
            want = due_q.pop_front();
            if (code !== want.code)
                flag($sformatf("key code: expected %02h, got %02h", want.code, code));
            if (kind !== want.kind)
                flag($sformatf("event kind: expected %0d, got %0d", want.kind, kind));
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    key_report_scoreboard sb = new();
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    key_press_repeat_reporter_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_report(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic hold_gap(int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic send_sample(bit row, bit col, bit pressed, logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) hold_gap(gap);
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, now, pressed, col, row};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(row, col, pressed, now);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== sb.reg_value(idx))
            sb.flag($sformatf("register %0d readback: expected %08h, got %08h",
                              idx, sb.reg_value(idx), prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_sample();
        int                slot;
        int                pick;
        bit                pressed;
        logic [TIME_W-1:0] limit;
        logic [TIME_W-1:0] offset;
        slot    = $urandom_range(0, SLOTS - 1);
        pressed = ($urandom_range(0, 3) != 0);
        limit   = sb.held[slot] ? TIME_W'(sb.repeat_ms) : TIME_W'(sb.hold_off_ms);
        pick    = $urandom_range(0, 9);
        if (pick == 0)
            offset = $urandom;
        else if (pick <= 3)
            offset = limit + $urandom_range(0, 2) - 1;
        else
            offset = $urandom_range(0, 2 * limit + 2);
        send_sample(1'(slot / KEY_COLS_DEF), 1'(slot % KEY_COLS_DEF), pressed,
                    sb.last_report[slot] + offset);
    endtask

    task automatic run_phase(logic [HOLD_W-1:0] hold_off, logic [HOLD_W-1:0] rep,
                             logic [MAP_W-1:0] map, int count);
        settle();
        apb_write(REG_HOLD_OFF, APB_DATA_W'(hold_off));
        apb_write(REG_REPEAT, APB_DATA_W'(rep));
        apb_write(REG_KEY_MAP, APB_DATA_W'(map));
        repeat (count) random_sample();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default registers: thresholds, wrap, release timing
        send_sample(0, 0, 1, 32'd50);
        send_sample(0, 0, 1, 32'd51);
        send_sample(0, 0, 1, 32'd551);
        send_sample(0, 0, 1, 32'd552);
        send_sample(0, 0, 0, 32'd552);
        send_sample(0, 0, 0, 32'd600);
        send_sample(0, 0, 1, 32'd600);
        send_sample(0, 0, 1, 32'd603);
        send_sample(0, 1, 1, 32'hFFFF_FFFF);
        send_sample(0, 1, 1, 32'h0000_01F3);
        send_sample(0, 1, 1, 32'h0000_01F4);
        send_sample(1, 0, 1, 32'h0000_0000);
        send_sample(1, 0, 1, 32'h8000_0000);
        send_sample(1, 1, 1, 32'd1000);
        send_sample(1, 1, 0, 32'd1000);
        send_sample(0, 1, 0, 32'd1000);
        send_sample(1, 0, 0, 32'h8000_0000);
        send_sample(0, 0, 0, 32'd1000);

        // zero thresholds and a zero code in the keymap
        settle();
        apb_write(REG_HOLD_OFF, '0);
        apb_write(REG_REPEAT, '0);
        apb_write(REG_KEY_MAP, 32'h80FF_0100);
        send_sample(0, 0, 1, 32'd1000);
        send_sample(0, 0, 1, 32'd1000);
        send_sample(0, 0, 1, 32'd1001);
        send_sample(0, 0, 0, 32'd1001);
        send_sample(1, 0, 1, 32'h8000_0000);
        send_sample(1, 0, 1, 32'h8000_0001);
        send_sample(1, 0, 0, 32'h8000_0001);

        run_phase('0, '0, '0, 300);
        run_phase(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 300);
        run_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)), $urandom, 350);
        run_phase(HOLD_OFF_RST, REPEAT_RST, KEY_MAP_RST, 350);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  $urandom, 350);
        run_phase(16'd3, 16'd7, $urandom, 350);

        settle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
